// ===== rtl/dbp_pkg.sv =====
// ---------------------------------------------------------------------------
// dbp_pkg
// Shared types, codes and helper functions of the delta binary packed decoder.
// ---------------------------------------------------------------------------
package dbp_pkg;

    localparam int MAX_MINIBLOCKS_DEF      = 4;
    localparam int MAX_MINIBLOCK_VALUES_DEF = 32;
    localparam int MAX_BIT_WIDTH           = 64;
    localparam int VARINT_LIMIT            = 70;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_DRAIN = 2'd1,
        OP_PAGE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CORRUPT = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_BSIZE    = 4'd0,
        PH_MBCOUNT  = 4'd1,
        PH_TOTAL    = 4'd2,
        PH_FIRST    = 4'd3,
        PH_MINDELTA = 4'd4,
        PH_WIDTHS   = 4'd5,
        PH_DATA     = 4'd6,
        PH_DONE     = 4'd7,
        PH_ERROR    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_SHAPE,
        SQ_COUNT,
        SQ_EMIT,
        SQ_REPORT
    } seq_t;

    // control of the bit buffer
    typedef struct packed {
        logic       clr;
        logic       ins;
        logic [6:0] pos;
        logic [7:0] din;
        logic       pop;
        logic [6:0] width;
    } bbuf_ctl_t;

    function automatic logic [63:0] wrap_value(input logic [63:0] v, input logic wide);
        logic [63:0] r;
        begin
            if (wide)
                r = v;
            else
                r = {{32{v[31]}}, v[31:0]};
            return r;
        end
    endfunction

    function automatic logic [63:0] unzigzag(input logic [63:0] u);
        logic [63:0] r;
        begin
            r = {1'b0, u[63:1]} ^ {64{u[0]}};
            return r;
        end
    endfunction

endpackage

// ===== rtl/dbp_bitbuf.sv =====
// ---------------------------------------------------------------------------
// dbp_bitbuf
// 128-bit lsb-first bit buffer: byte insert, width-masked extract, pop shift.
// ---------------------------------------------------------------------------
module dbp_bitbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  dbp_pkg::bbuf_ctl_t ctl,
    output logic [63:0]        delta
);

    logic [127:0] shreg_reg;
    logic [127:0] shreg_next;
    logic [63:0]  low;

    assign low = shreg_reg[63:0];

    // a width of 64 takes the whole low word
    assign delta = ctl.width[6] ? low : (low & ~({64{1'b1}} << ctl.width[5:0]));

    always_comb
    begin
        shreg_next = shreg_reg;
        if (ctl.clr)
            shreg_next = '0;
        else if (ctl.ins)
            shreg_next = shreg_reg | (128'(ctl.din) << ctl.pos);
        else if (ctl.pop)
            shreg_next = shreg_reg >> ctl.width;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shreg_reg <= '0;
        else
            shreg_reg <= shreg_next;
    end

endmodule

// ===== rtl/delta_binary_packed_decoder_top.sv =====
// ---------------------------------------------------------------------------
// delta_binary_packed_decoder_top
// Byte-serial delta binary packed page decoder, one value per cycle unless stalled.
// ---------------------------------------------------------------------------
// channel  direction  signals                      contents
// s_       in         s_tvalid s_tready s_tdata    data_byte [7:0]
//                     s_tuser                      operation [1:0]
// m_       out        m_tvalid m_tready m_tdata    value [63:0]
//                     m_tlast m_tuser              last_of_run, flags
// cfg_     in         cfg_valid cfg_ready cfg_data wide_values
//
// header and width bytes pass from idle to the report state; the miniblock count
// byte first searches the values per miniblock on the add/compare unit.
// a data byte yielding n deltas takes n+1 subtract steps to count the deltas,
// then emits one value per cycle through the adder while m_tready allows.
// a drain emits its values the same way. s_tready is high only between requests.
// reset clears all control state; no clearing pass is needed.
// m_tready low stalls the sequencer at its next result.
// ---------------------------------------------------------------------------
module delta_binary_packed_decoder_top #(
    parameter int MAX_MINIBLOCKS       = dbp_pkg::MAX_MINIBLOCKS_DEF,
    parameter int MAX_MINIBLOCK_VALUES = dbp_pkg::MAX_MINIBLOCK_VALUES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value
    output logic        m_tlast,   // last_of_run
    output logic [4:0]  m_tuser,   // value_valid, page_done, needs_drain, status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // wide_values
);

    localparam int MBW  = $clog2(MAX_MINIBLOCKS + 1);
    localparam int AW   = (MAX_MINIBLOCKS > 1) ? $clog2(MAX_MINIBLOCKS) : 1;
    localparam int VW   = $clog2(MAX_MINIBLOCK_VALUES + 1);
    localparam int KMAX = MAX_MINIBLOCK_VALUES / 8;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int TW   = $clog2(8 * KMAX * MAX_MINIBLOCKS + 1);

    dbp_pkg::seq_t      seq_reg, seq_next, idle_target;
    dbp_pkg::phase_t    phase_reg, phase_next;
    dbp_pkg::status_t   st_reg, st_next;
    dbp_pkg::op_t       op;
    dbp_pkg::bbuf_ctl_t ctl;

    logic [63:0]     acc_reg, acc_next;
    logic [6:0]      vshift_reg, vshift_next;
    logic [VW-1:0]   vpm_reg, vpm_next;
    logic [MBW-1:0]  mbpb_reg, mbpb_next;
    logic [31:0]     vlt_reg, vlt_next;
    logic [63:0]     run_reg, run_next;
    logic [63:0]     bmd_reg, bmd_next;
    logic [MBW-1:0]  idx_reg, idx_next;
    logic [VW-1:0]   vlm_reg, vlm_next;
    logic [6:0]      bits_reg, bits_next;
    logic            wide_reg;
    logic [VW-1:0]   q_reg, q_next;
    logic [VW-1:0]   lim_reg, lim_next;
    logic [VW-1:0]   ecnt_reg, ecnt_next;
    logic [6:0]      wcur_reg, wcur_next;
    logic            zero_d_reg, zero_d_next;
    logic            clr_reg, clr_next;
    logic            rvv_reg, rvv_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [TW-1:0]   trial_reg, trial_next;

    logic [6:0]      widths_mem [MAX_MINIBLOCKS];
    logic            wr_en;
    logic [AW-1:0]   wr_idx;
    logic [6:0]      wr_data;

    logic            o_valid_reg, o_vv_reg, o_last_reg, o_pd_reg, o_nd_reg;
    logic [63:0]     o_value_reg;
    logic [1:0]      o_st_reg;

    logic            push, push_vv, push_last;
    logic [63:0]     push_value;
    logic            out_free, s_accept;
    logic [7:0]      b;
    logic [63:0]     v_full, delta_raw, emit_sum, emit_val, first_val;
    logic [6:0]      vshift_inc, cw;
    logic            vdone, vover, drain_ok, count_go, shape_hit, shape_last;
    logic            do_update;
    logic [VW-1:0]   lim_c, n_upd, upd_vlm;
    logic [31:0]     upd_vlt;
    logic [MBW-1:0]  idx_inc;

    dbp_bitbuf u_bitbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .delta (delta_raw)
    );

    assign op        = dbp_pkg::op_t'(s_tuser);
    assign b         = s_tdata;
    assign s_tready  = (seq_reg == dbp_pkg::SQ_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !o_valid_reg || m_tready;

    assign v_full     = acc_reg | (vshift_reg[6] ? 64'd0 : (64'(b[6:0]) << vshift_reg[5:0]));
    assign vshift_inc = vshift_reg + 7'd7;
    assign vdone      = !b[7];
    assign vover      = b[7] && (vshift_inc >= 7'(dbp_pkg::VARINT_LIMIT));

    assign cw       = (idx_reg < MBW'(MAX_MINIBLOCKS)) ? widths_mem[idx_reg[AW-1:0]] : 7'd0;
    assign drain_ok = (phase_reg == dbp_pkg::PH_DATA) && (cw == 7'd0);
    assign lim_c    = (vlt_reg < 32'(vlm_reg)) ? VW'(vlt_reg) : vlm_reg;
    assign count_go = (bits_reg >= wcur_reg) && (q_reg < lim_reg);

    assign shape_hit  = (64'(trial_reg) == bmd_reg);
    assign shape_last = (k_reg == KW'(KMAX));

    assign n_upd   = (seq_reg == dbp_pkg::SQ_COUNT) ? q_reg : lim_c;
    assign upd_vlt = vlt_reg - 32'(n_upd);
    assign upd_vlm = vlm_reg - n_upd;
    assign idx_inc = idx_reg + 1'b1;

    assign emit_sum  = run_reg + (zero_d_reg ? 64'd0 : delta_raw) + bmd_reg;
    assign emit_val  = dbp_pkg::wrap_value(emit_sum, wide_reg);
    assign first_val = dbp_pkg::wrap_value(dbp_pkg::unzigzag(v_full), wide_reg);

    // sequencer
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            dbp_pkg::SQ_IDLE:
                if (s_accept)
                    seq_next = idle_target;
            dbp_pkg::SQ_SHAPE:
                if (shape_hit || shape_last)
                    seq_next = dbp_pkg::SQ_REPORT;
            dbp_pkg::SQ_COUNT:
                if (!count_go)
                    seq_next = (q_reg == '0) ? dbp_pkg::SQ_REPORT : dbp_pkg::SQ_EMIT;
            dbp_pkg::SQ_EMIT:
                if (out_free && ecnt_reg == VW'(1))
                    seq_next = dbp_pkg::SQ_IDLE;
            dbp_pkg::SQ_REPORT:
                if (out_free)
                    seq_next = dbp_pkg::SQ_IDLE;
            default:
                seq_next = dbp_pkg::SQ_IDLE;
        endcase
    end

    // datapath and parse state
    always_comb
    begin
        phase_next  = phase_reg;
        st_next     = st_reg;
        acc_next    = acc_reg;
        vshift_next = vshift_reg;
        vpm_next    = vpm_reg;
        mbpb_next   = mbpb_reg;
        vlt_next    = vlt_reg;
        run_next    = run_reg;
        bmd_next    = bmd_reg;
        idx_next    = idx_reg;
        vlm_next    = vlm_reg;
        bits_next   = bits_reg;
        q_next      = q_reg;
        lim_next    = lim_reg;
        ecnt_next   = ecnt_reg;
        wcur_next   = wcur_reg;
        zero_d_next = zero_d_reg;
        clr_next    = clr_reg;
        rvv_next    = rvv_reg;
        k_next      = k_reg;
        trial_next  = trial_reg;
        idle_target = dbp_pkg::SQ_REPORT;
        do_update   = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = idx_reg[AW-1:0];
        wr_data     = b[6:0];
        ctl         = '0;
        push        = 1'b0;
        push_vv     = 1'b0;
        push_last   = 1'b0;
        push_value  = 64'd0;

        unique case (seq_reg)
            dbp_pkg::SQ_IDLE:
            begin
                if (s_accept)
                begin
                    st_next  = dbp_pkg::ST_OK;
                    rvv_next = 1'b0;
                    clr_next = 1'b0;
                    unique case (op)
                        dbp_pkg::OP_PAGE:
                        begin
                            phase_next  = dbp_pkg::PH_BSIZE;
                            acc_next    = '0;
                            vshift_next = '0;
                            vpm_next    = '0;
                            mbpb_next   = '0;
                            vlt_next    = '0;
                            run_next    = '0;
                            bmd_next    = '0;
                            idx_next    = '0;
                            vlm_next    = '0;
                            bits_next   = '0;
                            ctl.clr     = 1'b1;
                        end
                        dbp_pkg::OP_NONE:
                            st_next = dbp_pkg::ST_IGNORED;
                        dbp_pkg::OP_DRAIN:
                        begin
                            if (drain_ok)
                            begin
                                do_update   = 1'b1;
                                zero_d_next = 1'b1;
                                ecnt_next   = lim_c;
                                idle_target = dbp_pkg::SQ_EMIT;
                            end
                            else
                                st_next = dbp_pkg::ST_IGNORED;
                        end
                        dbp_pkg::OP_BYTE:
                        begin
                            unique case (phase_reg)
                                dbp_pkg::PH_BSIZE, dbp_pkg::PH_MBCOUNT, dbp_pkg::PH_TOTAL,
                                dbp_pkg::PH_FIRST, dbp_pkg::PH_MINDELTA:
                                begin
                                    if (vover)
                                        st_next = dbp_pkg::ST_CORRUPT;
                                    else if (!vdone)
                                    begin
                                        acc_next    = v_full;
                                        vshift_next = vshift_inc;
                                    end
                                    else
                                    begin
                                        acc_next    = '0;
                                        vshift_next = '0;
                                        unique case (phase_reg)
                                            dbp_pkg::PH_BSIZE:
                                            begin
                                                bmd_next   = v_full;
                                                phase_next = dbp_pkg::PH_MBCOUNT;
                                            end
                                            dbp_pkg::PH_MBCOUNT:
                                            begin
                                                if (v_full == 64'd0 ||
                                                    v_full > 64'(MAX_MINIBLOCKS))
                                                    st_next = dbp_pkg::ST_CORRUPT;
                                                else
                                                begin
                                                    mbpb_next   = v_full[MBW-1:0];
                                                    k_next      = KW'(1);
                                                    trial_next  = TW'({v_full[MBW-1:0], 3'b000});
                                                    idle_target = dbp_pkg::SQ_SHAPE;
                                                end
                                            end
                                            dbp_pkg::PH_TOTAL:
                                            begin
                                                if (v_full[63:32] != 32'd0)
                                                    st_next = dbp_pkg::ST_CORRUPT;
                                                else
                                                begin
                                                    vlt_next   = v_full[31:0];
                                                    phase_next = dbp_pkg::PH_FIRST;
                                                end
                                            end
                                            dbp_pkg::PH_FIRST:
                                            begin
                                                run_next = first_val;
                                                if (vlt_reg == 32'd0)
                                                    phase_next = dbp_pkg::PH_DONE;
                                                else
                                                begin
                                                    rvv_next   = 1'b1;
                                                    vlt_next   = vlt_reg - 32'd1;
                                                    phase_next = (vlt_reg == 32'd1) ?
                                                        dbp_pkg::PH_DONE : dbp_pkg::PH_MINDELTA;
                                                end
                                            end
                                            default:
                                            begin
                                                bmd_next   = dbp_pkg::unzigzag(v_full);
                                                idx_next   = '0;
                                                phase_next = dbp_pkg::PH_WIDTHS;
                                            end
                                        endcase
                                    end
                                end
                                dbp_pkg::PH_WIDTHS:
                                begin
                                    if (b > 8'(dbp_pkg::MAX_BIT_WIDTH) ||
                                        idx_reg >= MBW'(MAX_MINIBLOCKS))
                                        st_next = dbp_pkg::ST_CORRUPT;
                                    else
                                    begin
                                        wr_en = 1'b1;
                                        if (idx_inc >= mbpb_reg)
                                        begin
                                            idx_next   = '0;
                                            vlm_next   = vpm_reg;
                                            bits_next  = '0;
                                            ctl.clr    = 1'b1;
                                            phase_next = dbp_pkg::PH_DATA;
                                        end
                                        else
                                            idx_next = idx_inc;
                                    end
                                end
                                dbp_pkg::PH_DATA:
                                begin
                                    if (cw == 7'd0)
                                        st_next = dbp_pkg::ST_IGNORED;
                                    else
                                    begin
                                        ctl.ins     = 1'b1;
                                        ctl.pos     = bits_reg;
                                        ctl.din     = b;
                                        bits_next   = bits_reg + 7'd8;
                                        q_next      = '0;
                                        lim_next    = lim_c;
                                        wcur_next   = cw;
                                        zero_d_next = 1'b0;
                                        idle_target = dbp_pkg::SQ_COUNT;
                                    end
                                end
                                default:
                                    st_next = dbp_pkg::ST_IGNORED;
                            endcase
                        end
                        default:
                            st_next = dbp_pkg::ST_IGNORED;
                    endcase
                end
            end
            dbp_pkg::SQ_SHAPE:
            begin
                if (shape_hit)
                begin
                    vpm_next   = VW'({k_reg, 3'b000});
                    bmd_next   = '0;
                    phase_next = dbp_pkg::PH_TOTAL;
                end
                else if (shape_last)
                    st_next = dbp_pkg::ST_CORRUPT;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    trial_next = trial_reg + TW'({mbpb_reg, 3'b000});
                end
            end
            dbp_pkg::SQ_COUNT:
            begin
                if (count_go)
                begin
                    bits_next = bits_reg - wcur_reg;
                    q_next    = q_reg + 1'b1;
                end
                else
                begin
                    do_update = 1'b1;
                    ecnt_next = q_reg;
                end
            end
            dbp_pkg::SQ_EMIT:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_vv    = 1'b1;
                    push_value = emit_val;
                    push_last  = (ecnt_reg == VW'(1));
                    run_next   = emit_val;
                    ecnt_next  = ecnt_reg - 1'b1;
                    ctl.pop    = !zero_d_reg;
                    ctl.width  = wcur_reg;
                    // miniblock finished: drop its padding bits
                    ctl.clr    = push_last && clr_reg;
                end
            end
            dbp_pkg::SQ_REPORT:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_vv    = rvv_reg;
                    push_value = rvv_reg ? run_reg : 64'd0;
                    push_last  = 1'b1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase

        // counters move ahead of the emitted values
        if (do_update)
        begin
            vlt_next = upd_vlt;
            if (upd_vlt == 32'd0)
            begin
                vlm_next   = upd_vlm;
                phase_next = dbp_pkg::PH_DONE;
            end
            else if (upd_vlm == '0)
            begin
                clr_next  = 1'b1;
                bits_next = '0;
                if (idx_inc >= mbpb_reg)
                begin
                    idx_next    = '0;
                    acc_next    = '0;
                    vshift_next = '0;
                    phase_next  = dbp_pkg::PH_MINDELTA;
                end
                else
                begin
                    idx_next = idx_inc;
                    vlm_next = vpm_reg;
                end
            end
            else
                vlm_next = upd_vlm;
        end

        if (st_next == dbp_pkg::ST_CORRUPT)
            phase_next = dbp_pkg::PH_ERROR;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            widths_mem[wr_idx] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= dbp_pkg::SQ_IDLE;
            phase_reg  <= dbp_pkg::PH_BSIZE;
            st_reg     <= dbp_pkg::ST_OK;
            acc_reg    <= '0;
            vshift_reg <= '0;
            vpm_reg    <= '0;
            mbpb_reg   <= '0;
            vlt_reg    <= '0;
            run_reg    <= '0;
            bmd_reg    <= '0;
            idx_reg    <= '0;
            vlm_reg    <= '0;
            bits_reg   <= '0;
            wide_reg   <= 1'b0;
            q_reg      <= '0;
            lim_reg    <= '0;
            ecnt_reg   <= '0;
            wcur_reg   <= '0;
            zero_d_reg <= 1'b0;
            clr_reg    <= 1'b0;
            rvv_reg    <= 1'b0;
            k_reg      <= '0;
            trial_reg  <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg    <= seq_next;
            phase_reg  <= phase_next;
            st_reg     <= st_next;
            acc_reg    <= acc_next;
            vshift_reg <= vshift_next;
            vpm_reg    <= vpm_next;
            mbpb_reg   <= mbpb_next;
            vlt_reg    <= vlt_next;
            run_reg    <= run_next;
            bmd_reg    <= bmd_next;
            idx_reg    <= idx_next;
            vlm_reg    <= vlm_next;
            bits_reg   <= bits_next;
            q_reg      <= q_next;
            lim_reg    <= lim_next;
            ecnt_reg   <= ecnt_next;
            wcur_reg   <= wcur_next;
            zero_d_reg <= zero_d_next;
            clr_reg    <= clr_next;
            rvv_reg    <= rvv_next;
            k_reg      <= k_next;
            trial_reg  <= trial_next;
            if (cfg_valid && cfg_ready)
                wide_reg <= cfg_data;
            if (push)
                o_valid_reg <= 1'b1;
            else if (m_tready)
                o_valid_reg <= 1'b0;
        end
    end

    // result register; flags reflect the state after the whole request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            o_value_reg <= push_value;
            o_vv_reg    <= push_vv;
            o_last_reg  <= push_last;
            o_pd_reg    <= (phase_reg == dbp_pkg::PH_DONE);
            o_nd_reg    <= drain_ok;
            o_st_reg    <= st_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_value_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_st_reg, o_nd_reg, o_pd_reg, o_vv_reg};

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == dbp_pkg::SQ_EMIT) |-> (ecnt_reg != '0))
        else $error("emit state with no values left to emit");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == dbp_pkg::SQ_IDLE && o_valid_reg) |-> o_last_reg)
        else $error("new request taken before last result of previous one");

    a_data_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dbp_pkg::PH_DATA && seq_reg == dbp_pkg::SQ_IDLE)
            |-> (vlm_reg != '0 && vlt_reg != 32'd0))
        else $error("data phase with exhausted counters");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == dbp_pkg::SQ_IDLE) |-> (bits_reg < 7'd64))
        else $error("bit buffer holds a full delta between requests");

endmodule

// ===== tb/tb_delta_binary_packed_decoder_top.sv =====
// ---------------------------------------------------------------------------
// tb_delta_binary_packed_decoder_top
// Feeds directed and random delta binary packed pages, byte by byte, into the
// decoder and compares every result against a cycle-free software decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_delta_binary_packed_decoder_top;
    import dbp_pkg::*;

    localparam int MB_MAX  = 4;
    localparam int MBV_MAX = 32;

    typedef struct {
        op_t        op;
        logic [7:0] b;
    } page_req_t;

    typedef struct {
        logic [63:0] value;
        logic        valid;
        logic        last;
        logic        done;
        logic        drain;
        status_t     status;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [4:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    page_req_t   pending_reqs[$];
    decoded_t    decoded_q[$];
    int          mismatches = 0;
    logic        calm = 1'b0;
    int          send_gap = 0;
    int          recv_stall = 0;

    // software decoder state
    logic        wide;
    phase_t      phase;
    logic [63:0] vacc;
    int          vshift;
    int          per_mb;
    int          mb_count;
    logic [31:0] left_total;
    logic [63:0] running;
    logic [63:0] min_delta;
    int          widths[MB_MAX];
    int          mb_idx;
    int          left_mb;
    logic [127:0] bitbuf;
    int          held;
    logic [63:0] outv[64];
    int          nout;

    delta_binary_packed_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [63:0] wrapped(input logic [63:0] v);
        if (wide)
            return v;
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] from_zigzag(input logic [63:0] u);
        return {1'b0, u[63:1]} ^ {64{u[0]}};
    endfunction

    function automatic void clear_page();
        phase = PH_BSIZE;
        vacc = '0;
        vshift = 0;
        per_mb = 0;
        mb_count = 0;
        left_total = '0;
        running = '0;
        min_delta = '0;
        for (int i = 0; i < MB_MAX; i++)
            widths[i] = 0;
        mb_idx = 0;
        left_mb = 0;
        bitbuf = '0;
        held = 0;
    endfunction

    function automatic int cur_width();
        return (mb_idx < MB_MAX) ? widths[mb_idx] : 0;
    endfunction

    function automatic void emit_delta(input logic [63:0] d);
        running = wrapped(running + d + min_delta);
        if (nout < 64)
        begin
            outv[nout] = running;
            nout++;
        end
        if (left_mb > 0)
            left_mb--;
        if (left_total > 0)
            left_total--;
    endfunction

    function automatic void finish_values();
        if (left_total == 0)
        begin
            phase = PH_DONE;
            return;
        end
        if (left_mb != 0)
            return;
        mb_idx++;
        bitbuf = '0;
        held = 0;
        if (mb_idx >= mb_count)
        begin
            mb_idx = 0;
            vacc = '0;
            vshift = 0;
            phase = PH_MINDELTA;
        end
        else
            left_mb = per_mb;
    endfunction

    // returns corrupt flag
    function automatic logic header_in(input logic [7:0] b);
        logic [63:0] v;
        if (vshift < 64)
            vacc = vacc | ({57'd0, b[6:0]} << vshift);
        vshift += 7;
        if (b[7])
            return vshift >= 70;
        vshift = 0;
        v = vacc;
        vacc = '0;
        case (phase)
            PH_BSIZE:
            begin
                min_delta = v;
                phase = PH_MBCOUNT;
            end
            PH_MBCOUNT:
            begin
                if (v == 0 || v > MB_MAX || (min_delta % v) != 0)
                    return 1'b1;
                if ((min_delta / v) == 0 || (min_delta / v) % 8 != 0
                    || (min_delta / v) > MBV_MAX)
                    return 1'b1;
                mb_count = int'(v);
                per_mb = int'(min_delta / v);
                min_delta = '0;
                phase = PH_TOTAL;
            end
            PH_TOTAL:
            begin
                if (v > 64'hFFFF_FFFF)
                    return 1'b1;
                left_total = v[31:0];
                phase = PH_FIRST;
            end
            PH_FIRST:
            begin
                running = wrapped(from_zigzag(v));
                if (left_total == 0)
                    phase = PH_DONE;
                else
                begin
                    outv[nout] = running;
                    nout++;
                    left_total--;
                    phase = (left_total == 0) ? PH_DONE : PH_MINDELTA;
                end
            end
            default:
            begin
                min_delta = from_zigzag(v);
                mb_idx = 0;
                phase = PH_WIDTHS;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void unpack_byte(input logic [7:0] b);
        int          w;
        logic [63:0] d;
        w = cur_width();
        bitbuf = bitbuf | ({120'd0, b} << held);
        held += 8;
        while (held >= w && left_mb > 0 && left_total > 0 && nout < 64)
        begin
            d = (w >= 64) ? bitbuf[63:0] : (bitbuf[63:0] & ((64'd1 << w) - 64'd1));
            bitbuf = bitbuf >> w;
            held -= w;
            emit_delta(d);
        end
        finish_values();
    endfunction

    function automatic void decode_req(input op_t op, input logic [7:0] b);
        status_t  st;
        decoded_t r;
        st = ST_OK;
        nout = 0;
        case (op)
            OP_PAGE: clear_page();
            OP_NONE: st = ST_IGNORED;
            OP_DRAIN:
            begin
                if (phase == PH_DATA && cur_width() == 0)
                begin
                    while (left_mb > 0 && left_total > 0 && nout < 64)
                        emit_delta('0);
                    finish_values();
                end
                else
                    st = ST_IGNORED;
            end
            default:
            begin
                case (phase)
                    PH_BSIZE, PH_MBCOUNT, PH_TOTAL, PH_FIRST, PH_MINDELTA:
                        st = header_in(b) ? ST_CORRUPT : ST_OK;
                    PH_WIDTHS:
                    begin
                        if (b > 64 || mb_idx >= MB_MAX)
                            st = ST_CORRUPT;
                        else
                        begin
                            widths[mb_idx] = b;
                            mb_idx++;
                            if (mb_idx >= mb_count)
                            begin
                                mb_idx = 0;
                                left_mb = per_mb;
                                bitbuf = '0;
                                held = 0;
                                phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (cur_width() == 0)
                            st = ST_IGNORED;
                        else
                            unpack_byte(b);
                    end
                    default: st = ST_IGNORED;
                endcase
            end
        endcase
        if (st == ST_CORRUPT)
            phase = PH_ERROR;
        if (nout == 0)
        begin
            outv[0] = '0;
            nout = 1;
            r.valid = 1'b0;
        end
        else
            r.valid = 1'b1;
        for (int k = 0; k < nout; k++)
        begin
            r.value = outv[k];
            r.last = (k == nout - 1);
            r.done = (phase == PH_DONE);
            r.drain = (phase == PH_DATA && cur_width() == 0);
            r.status = st;
            decoded_q.push_back(r);
        end
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        page_req_t it;
        logic      nv;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                decode_req(op_t'(s_tuser), s_tdata);
            if (!(s_tvalid && !s_tready))
            begin
                nv = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() > 0)
                begin
                    it = pending_reqs.pop_front();
                    s_tuser <= it.op;
                    s_tdata <= it.b;
                    nv = 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 6);
                end
                s_tvalid <= nv;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t e;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                    report("unexpected result", m_tdata, '0);
                else
                begin
                    e = decoded_q.pop_front();
                    if (m_tdata !== e.value)
                        report("value", m_tdata, e.value);
                    if (m_tuser[0] !== e.valid)
                        report("value_valid", m_tuser[0], e.valid);
                    if (m_tlast !== e.last)
                        report("last_of_run", m_tlast, e.last);
                    if (m_tuser[1] !== e.done)
                        report("page_done", m_tuser[1], e.done);
                    if (m_tuser[2] !== e.drain)
                        report("needs_drain", m_tuser[2], e.drain);
                    if (m_tuser[4:3] !== e.status)
                        report("status", m_tuser[4:3], e.status);
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    recv_stall = $urandom_range(1, 6);
            end
        end
    end

    task automatic put(input op_t op, input logic [7:0] b);
        page_req_t it;
        it.op = op;
        it.b = b;
        pending_reqs.push_back(it);
    endtask

    task automatic put_varint(input logic [63:0] v);
        do
        begin
            put(OP_BYTE, {(v >> 7) != 0, v[6:0]});
            v = v >> 7;
        end while (v != 0);
    endtask

    function automatic logic [63:0] to_zigzag(input logic [63:0] v);
        return (v << 1) ^ {64{v[63]}};
    endfunction

    // one well-formed page with random content
    task automatic put_page();
        int          mbc;
        int          per;
        int          total;
        int          made;
        int          w;
        int          sel;
        logic [63:0] md;
        mbc = $urandom_range(1, MB_MAX);
        per = 8 * $urandom_range(1, MBV_MAX / 8);
        total = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 40);
        put(OP_PAGE, 8'($urandom));
        put_varint(mbc * per);
        put_varint(mbc);
        put_varint(total);
        put_varint(to_zigzag({$urandom, $urandom} >>> $urandom_range(0, 63)));
        made = 1;
        while (made < total)
        begin
            md = {$urandom, $urandom};
            if ($urandom_range(0, 2) != 0)
                md = 64'($signed(md) >>> 58);
            put_varint(to_zigzag(md));
            for (int i = 0; i < mbc; i++)
            begin
                sel = $urandom_range(0, 9);
                widths[i] = 0;
            end
            for (int i = 0; i < mbc; i++)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    w = 0;
                else if (sel <= 7)
                    w = $urandom_range(1, 8);
                else if (sel == 8)
                    w = $urandom_range(9, 32);
                else
                    w = (per == 8) ? $urandom_range(33, 64) : $urandom_range(1, 4);
                put(OP_BYTE, 8'(w));
                sel = w;
                // stash each width in outv for the data bytes that follow
                outv[i] = 64'(sel);
            end
            for (int i = 0; i < mbc; i++)
            begin
                w = int'(outv[i]);
                if (w == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        put(OP_BYTE, 8'($urandom));
                    put(OP_DRAIN, 8'($urandom));
                end
                else
                    for (int k = 0; k < per * w / 8; k++)
                        put(OP_BYTE, 8'($urandom));
            end
            made += mbc * per;
        end
        if ($urandom_range(0, 3) == 0)
            put(OP_BYTE, 8'($urandom));
    endtask

    task automatic put_noise();
        put(op_t'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_tvalid || decoded_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_wide(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        wide = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_part(input int n);
        int start;
        start = pending_reqs.size();
        while (pending_reqs.size() - start < n)
        begin
            if ($urandom_range(0, 9) == 0)
                put_noise();
            else
                put_page();
        end
    endtask

    initial
    begin
        wide = 1'b0;
        clear_page();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // unused operation, misplaced drain, zero total then byte after end
        put(OP_NONE, 8'hFF);
        put(OP_DRAIN, 8'h00);
        put(OP_PAGE, 8'h00);
        put_varint(8);
        put_varint(1);
        put_varint(0);
        put_varint(0);
        put(OP_BYTE, 8'hA5);
        // overlong varint, then ignored byte
        put(OP_PAGE, 8'h00);
        for (int i = 0; i < 10; i++)
            put(OP_BYTE, 8'hFF);
        put(OP_BYTE, 8'h01);
        // bad block shape
        put(OP_PAGE, 8'h00);
        put_varint(8);
        put_varint(3);
        // extreme first value, zero-width miniblock, byte while draining
        put(OP_PAGE, 8'h00);
        put_varint(8);
        put_varint(1);
        put_varint(3);
        put_varint(to_zigzag(64'h8000_0000_0000_0000));
        put_varint(to_zigzag(64'h7FFF_FFFF_FFFF_FFFF));
        put(OP_BYTE, 8'h00);
        put(OP_BYTE, 8'h55);
        put(OP_DRAIN, 8'h00);
        wait_idle();
        // width byte too wide
        put(OP_PAGE, 8'h00);
        put_varint(8);
        put_varint(1);
        put_varint(2);
        put_varint(0);
        put_varint(0);
        put(OP_BYTE, 8'd65);
        wait_idle();

        random_part(350);
        wait_idle();
        write_wide(1'b1);
        random_part(350);
        wait_idle();
        write_wide(1'b0);
        random_part(250);
        wait_idle();
        write_wide(1'b1);
        calm = 1'b1;
        random_part(200);
        wait_idle();

        if (mismatches == 0)
            $display("tb_delta_binary_packed_decoder_top: done, clean");
        else
            $display("tb_delta_binary_packed_decoder_top: done, errors");
        $finish;
    end

    initial
    begin
        #(8 * 1_500_000);
        $display("tb_delta_binary_packed_decoder_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dbp_pkg.sv
rtl/dbp_bitbuf.sv
rtl/delta_binary_packed_decoder_top.sv
tb/tb_delta_binary_packed_decoder_top.sv
